// ----- sv/abl_pkg.sv -----
`timescale 1ns / 1ps
package abl_pkg;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 30;
  localparam int unsigned CoefBits     = 32;
  localparam int unsigned ConstBits    = 49;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = 2;

  // One classified item, handed from the front to the back.
  typedef struct packed {
    logic signed [24:0] vx;
    logic signed [24:0] vy;
    logic signed [25:0] px;
    logic signed [25:0] py;
    logic signed [25:0] qx;
    logic signed [25:0] qy;
    logic               degen;
  } abl_item_t;

  // Queue occupancy status passed to the front.
  typedef struct packed {
    logic full;
  } abl_qstat_t;

  // States of the vector normalizer.
  typedef enum logic [2:0] {U_IDLE, U_SQR, U_NORM, U_SQRT, U_DIV, U_DONE} ust_e;

  // States of the back end sequencer.
  typedef enum logic [2:0] {B_IDLE, B_UP, B_UQ, B_W, B_C, B_OUT} bst_e;
endpackage

// ----- sv/abl_front.sv -----
`timescale 1ns / 1ps
module abl_front #(
  parameter int unsigned COORD_BITS = abl_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  stall_i,
  input  logic [COORD_BITS-1:0] vertex_x_i,
  input  logic [COORD_BITS-1:0] vertex_y_i,
  input  logic [COORD_BITS-1:0] first_x_i,
  input  logic [COORD_BITS-1:0] first_y_i,
  input  logic [COORD_BITS-1:0] second_x_i,
  input  logic [COORD_BITS-1:0] second_y_i,
  output logic                  valid_o,
  output abl_pkg::abl_item_t    item_o
);
  import abl_pkg::*;

  // Stage 1: differences and zero tests.
  logic               s1_v_q;
  logic signed [24:0] vx_q, vy_q;
  logic signed [25:0] px_q, py_q, qx_q, qy_q;
  logic               zero_q;
  logic signed [25:0] px_d, py_d, qx_d, qy_d;
  logic signed [24:0] vx_d, vy_d;

  always_comb begin
    vx_d = 25'(signed'(vertex_x_i));
    vy_d = 25'(signed'(vertex_y_i));
    px_d = 26'(signed'(first_x_i)) - 26'(vx_d);
    py_d = 26'(signed'(first_y_i)) - 26'(vy_d);
    qx_d = 26'(signed'(second_x_i)) - 26'(vx_d);
    qy_d = 26'(signed'(second_y_i)) - 26'(vy_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (!stall_i) begin
      s1_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      vx_q <= vx_d; vy_q <= vy_d;
      px_q <= px_d; py_q <= py_d; qx_q <= qx_d; qy_q <= qy_d;
      zero_q <= (px_d == '0 && py_d == '0) || (qx_d == '0 && qy_d == '0);
    end
  end

  // Stage 2: cross and dot products, opposite-arm test.
  logic signed [52:0] m1_q, m2_q, m3_q, m4_q;
  logic               s2_v_q;
  abl_item_t          it2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (!stall_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      m1_q <= 53'(px_q * qy_q);
      m2_q <= 53'(py_q * qx_q);
      m3_q <= 53'(px_q * qx_q);
      m4_q <= 53'(py_q * qy_q);
      it2_q <= '{vx: vx_q, vy: vy_q, px: px_q, py: py_q, qx: qx_q, qy: qy_q,
                 degen: zero_q};
    end
  end

  logic signed [53:0] dot;
  always_comb begin
    dot = 54'(m3_q) + 54'(m4_q);
    item_o = it2_q;
    item_o.degen = it2_q.degen || (m1_q == m2_q && dot < 0);
    valid_o = s2_v_q && !stall_i;
  end
endmodule

// ----- sv/abl_unit.sv -----
`timescale 1ns / 1ps
module abl_unit #(
  parameter int unsigned FRAC_BITS = abl_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [33:0] x_i,
  input  logic signed [33:0] y_i,
  output logic               done_o,
  output logic signed [33:0] ox_o,
  output logic signed [33:0] oy_o
);
  import abl_pkg::*;

  ust_e st_q, st_d;

  logic [31:0] ax_q, ay_q;
  logic        nx_q, ny_q;
  logic [63:0] s_q, rem_q, bit_q, r_q;
  logic [5:0]  k_q;
  logic [63:0] nx_num_q, ny_num_q;
  logic [31:0] rx_q, ry_q;
  logic [6:0]  cnt_q;
  logic        take;

  logic [33:0] mag_x, mag_y;
  logic [63:0] sq_x, sq_y;
  logic [64:0] trial;
  logic [63:0] r_next;
  logic [31:0] len;
  logic [33:0] tx, ty;

  // A new vector is taken while idle or in the cycle that presents a result.
  assign take = go_i && (st_q == U_IDLE || st_q == U_DONE);

  always_comb begin
    st_d = st_q;
    case (st_q)
      U_IDLE:  if (go_i) st_d = U_SQR;
      U_SQR:   st_d = U_NORM;
      U_NORM:  if (s_q[63:60] != '0) st_d = U_SQRT;
      U_SQRT:  if (bit_q == 64'd1) st_d = U_DIV;
      U_DIV:   if (cnt_q == 7'd1) st_d = U_DONE;
      U_DONE:  st_d = go_i ? U_SQR : U_IDLE;
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= U_IDLE;
    else st_q <= st_d;
  end

  always_comb begin
    mag_x = x_i[33] ? -x_i : x_i;
    mag_y = y_i[33] ? -y_i : y_i;
    sq_x = ax_q * ax_q;
    sq_y = ay_q * ay_q;
    trial = 65'(rem_q) - 65'(r_q) - 65'(bit_q);
    r_next = trial[64] ? (r_q >> 1) : ((r_q >> 1) + bit_q);
    len = r_q[31:0];
    // Restoring division: one quotient bit per cycle for each component.
    tx = {1'b0, rx_q, nx_num_q[63]} - {2'b00, len};
    ty = {1'b0, ry_q, ny_num_q[63]} - {2'b00, len};
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ax_q <= mag_x[31:0]; ay_q <= mag_y[31:0];
      nx_q <= x_i[33]; ny_q <= y_i[33];
    end
    case (st_q)
      U_SQR: begin
        s_q <= sq_x + sq_y;
        k_q <= '0;
      end
      U_NORM: begin
        if (s_q[63:60] == '0) begin
          s_q <= s_q << 2; k_q <= k_q + 6'd1;
        end else begin
          rem_q <= s_q; r_q <= '0;
          bit_q <= s_q[63:62] != '0 ? 64'd1 << 62 : 64'd1 << 60;
        end
      end
      U_SQRT: begin
        if (!trial[64]) rem_q <= trial[63:0];
        r_q <= r_next;
        bit_q <= bit_q >> 2;
        if (bit_q == 64'd1) begin
          // The root is final this cycle; the numerators carry half of it
          // so that the quotient rounds half away from zero.
          nx_num_q <= (64'(ax_q) << (k_q + 6'(FRAC_BITS))) + (r_next >> 1);
          ny_num_q <= (64'(ay_q) << (k_q + 6'(FRAC_BITS))) + (r_next >> 1);
          rx_q <= '0; ry_q <= '0;
          cnt_q <= 7'd64;
        end
      end
      U_DIV: begin
        rx_q <= tx[33] ? {rx_q[30:0], nx_num_q[63]} : tx[31:0];
        ry_q <= ty[33] ? {ry_q[30:0], ny_num_q[63]} : ty[31:0];
        nx_num_q <= {nx_num_q[62:0], ~tx[33]};
        ny_num_q <= {ny_num_q[62:0], ~ty[33]};
        cnt_q <= cnt_q - 7'd1;
      end
      default: ;
    endcase
  end

  assign done_o = (st_q == U_DONE);
  assign ox_o = nx_q ? -signed'(nx_num_q[33:0]) : signed'(nx_num_q[33:0]);
  assign oy_o = ny_q ? -signed'(ny_num_q[33:0]) : signed'(ny_num_q[33:0]);
endmodule

// ----- sv/abl_back.sv -----
`timescale 1ns / 1ps
module abl_back #(
  parameter int unsigned FRAC_BITS = abl_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  abl_pkg::abl_item_t                item_i,
  output abl_pkg::abl_qstat_t               qstat_o,
  output logic                              strobe_o,
  output logic [abl_pkg::CoefBits-1:0]      coef_a_o,
  output logic [abl_pkg::CoefBits-1:0]      coef_b_o,
  output logic [abl_pkg::ConstBits-1:0]     coef_c_o,
  output logic                              degenerate_o
);
  import abl_pkg::*;

  abl_item_t mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wp_q, rp_q;
  logic [QueuePtrBits:0]   cnt_q;
  logic pop;

  bst_e st_q, st_d;
  abl_item_t cur_q;
  logic signed [33:0] upx_q, upy_q, wx, wy;
  logic               ugo, udone;
  logic signed [33:0] ux, uy, ox, oy;

  assign pop = (st_q == B_IDLE) && cnt_q != '0;
  assign qstat_o.full  = cnt_q >= (QueuePtrBits+1)'(QueueDepth - 2);

  always_ff @(posedge clk_i) begin
    if (valid_i) mem_q[wp_q] <= item_i;
    if (pop) cur_q <= mem_q[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; st_q <= B_IDLE;
    end else begin
      if (valid_i) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrBits+1)'(valid_i) - (QueuePtrBits+1)'(pop);
      st_q <= st_d;
    end
  end

  assign wx = upx_q + ox;
  assign wy = upy_q + oy;

  always_comb begin
    st_d = st_q; ugo = 1'b0; ux = '0; uy = '0;
    case (st_q)
      B_IDLE: if (pop) st_d = B_UP;
      B_UP: begin
        if (cur_q.degen) st_d = B_OUT;
        else begin ugo = 1'b1; ux = 34'(cur_q.px); uy = 34'(cur_q.py); st_d = B_UQ; end
      end
      B_UQ: if (udone) st_d = B_W;
      B_W: if (udone) st_d = B_C;
      B_C: if (udone) st_d = B_OUT;
      B_OUT: st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
    if (st_q == B_UQ && udone) begin ugo = 1'b1; ux = 34'(cur_q.qx); uy = 34'(cur_q.qy); end
    if (st_q == B_W && udone) begin
      if (wx == '0 && wy == '0) st_d = B_OUT;
      else begin ugo = 1'b1; ux = wy; uy = -wx; end
    end
  end

  abl_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk_i, .rst_ni, .go_i(ugo), .x_i(ux), .y_i(uy), .done_o(udone), .ox_o(ox), .oy_o(oy)
  );

  logic               dg_q;
  logic signed [33:0] a_q, b_q;
  logic signed [60:0] c_full;
  always_ff @(posedge clk_i) begin
    if (st_q == B_UP) dg_q <= cur_q.degen;
    if (st_q == B_UQ && udone) begin upx_q <= ox; upy_q <= oy; end
    if (st_q == B_W && udone && wx == '0 && wy == '0) dg_q <= 1'b1;
    if (st_q == B_C && udone) begin a_q <= ox; b_q <= oy; end
  end

  always_comb begin
    c_full = -(61'(a_q * cur_q.vx) + 61'(b_q * cur_q.vy));
  end

  assign strobe_o = (st_q == B_OUT);
  assign degenerate_o = dg_q;
  assign coef_a_o = dg_q ? '0 : a_q[31:0];
  assign coef_b_o = dg_q ? '0 : b_q[31:0];
  assign coef_c_o = dg_q ? '0 :
    (c_full > 61'sd281474976710655) ? 49'h0ffffffffffff :
    (c_full < -61'sd281474976710656) ? 49'h1000000000000 : c_full[48:0];

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QueueDepth)
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_str: assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o |=> !strobe_o)
    else $error("double strobe");
`endif
endmodule

// ----- sv/angle_bisector_line_top.sv -----
`timescale 1ns / 1ps
// Channel | Signals                                   | Transfer
// input   | start, busy, six coordinate ports         | start && !busy
// result  | done_o, coef_a_o, coef_b_o, coef_c_o, ... | done_o, one cycle
// The front takes one transfer per cycle while busy is low into a two-stage
// classifier and a four-entry queue; busy rises once the queue holds two
// entries. The back works one item at a time through a shared iterative
// normalizer (square, shift, square root, divide) used up to three times per
// item: once for each arm and once for the bisector direction.
// Reset clears control state. The receiver cannot stall.
module angle_bisector_line_top #(
  parameter int unsigned COORD_BITS = abl_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = abl_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [COORD_BITS-1:0]            vertex_x_i,
  input  logic [COORD_BITS-1:0]            vertex_y_i,
  input  logic [COORD_BITS-1:0]            first_x_i,
  input  logic [COORD_BITS-1:0]            first_y_i,
  input  logic [COORD_BITS-1:0]            second_x_i,
  input  logic [COORD_BITS-1:0]            second_y_i,
  output logic                             done_o,
  output logic [abl_pkg::CoefBits-1:0]     coef_a_o,
  output logic [abl_pkg::CoefBits-1:0]     coef_b_o,
  output logic [abl_pkg::ConstBits-1:0]    coef_c_o,
  output logic                             degenerate_o
);
  import abl_pkg::*;

  abl_qstat_t qs;
  abl_item_t  it;
  logic       iv;

  // Busy holds the front whenever the queue could not absorb what is in flight.
  assign busy = qs.full;

  abl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .start_i(start && !busy), .stall_i(1'b0),
    .vertex_x_i, .vertex_y_i, .first_x_i, .first_y_i, .second_x_i, .second_y_i,
    .valid_o(iv), .item_o(it)
  );

  abl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(iv), .item_i(it), .qstat_o(qs), .strobe_o(done_o),
    .coef_a_o, .coef_b_o, .coef_c_o, .degenerate_o
  );
endmodule

// ----- tb/angle_bisector_line_top_tb.sv -----
`timescale 1ns / 1ps
module angle_bisector_line_top_tb;
  import abl_pkg::*;

  // Fraction bits of the coefficients at the default build.
  localparam int unsigned Frac = FracBitsDef;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  // Expected bisector line for one accepted point triple.
  typedef struct {
    logic [CoefBits-1:0]  a;
    logic [CoefBits-1:0]  b;
    logic [ConstBits-1:0] c;
    logic                 degen;
  } bisector_t;

  // Keeps the bisector lines still owed by the block, oldest first, and
  // works each one out from the coordinates of the accepted transfer.
  class bisector_board;
    bisector_t owed[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned degen_seen;

    function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r;
      longint unsigned bt;
      r = 0;
      bt = 64'h4000_0000_0000_0000;
      while (bt > s) bt = bt >> 2;
      while (bt != 0) begin
        if (s >= r + bt) begin
          s = s - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
      return r;
    endfunction

    function automatic longint scale_part(longint v, int k, longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      q = (((mag << k) << Frac) + (len >> 1)) / len;
      return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Scales a nonzero vector to unit length in the fixed-point format.
    function automatic void to_unit(longint x, longint y, output longint ox,
                                    output longint oy);
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned s;
      int k;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      s = ax * ax + ay * ay;
      k = 0;
      while (s < 64'h1000_0000_0000_0000) begin
        s = s << 2;
        k++;
      end
      ox = scale_part(x, k, int_sqrt(s));
      oy = scale_part(y, k, int_sqrt(s));
    endfunction

    function automatic void note(logic [15:0] vxi, logic [15:0] vyi,
                                 logic [15:0] pxi, logic [15:0] pyi,
                                 logic [15:0] qxi, logic [15:0] qyi);
      longint vx, vy, px, py, qx, qy;
      longint upx, upy, uqx, uqy, wx, wy, a, b, c;
      bisector_t e;
      bit dg;
      vx = longint'($signed(vxi));
      vy = longint'($signed(vyi));
      px = longint'($signed(pxi)) - vx;
      py = longint'($signed(pyi)) - vy;
      qx = longint'($signed(qxi)) - vx;
      qy = longint'($signed(qyi)) - vy;
      a = 0;
      b = 0;
      c = 0;
      dg = 0;
      if ((px == 0 && py == 0) || (qx == 0 && qy == 0)) begin
        dg = 1;
      end else if (px * qy - py * qx == 0 && px * qx + py * qy < 0) begin
        dg = 1;
      end else begin
        to_unit(px, py, upx, upy);
        to_unit(qx, qy, uqx, uqy);
        wx = upx + uqx;
        wy = upy + uqy;
        if (wx == 0 && wy == 0) begin
          dg = 1;
        end else begin
          to_unit(wy, -wx, a, b);
          c = -(a * vx + b * vy);
          if (c > (longint'(1) << 48) - 1) c = (longint'(1) << 48) - 1;
          if (c < -(longint'(1) << 48)) c = -(longint'(1) << 48);
        end
      end
      if (dg) begin
        a = 0;
        b = 0;
        c = 0;
      end
      e.a = a[CoefBits-1:0];
      e.b = b[CoefBits-1:0];
      e.c = c[ConstBits-1:0];
      e.degen = dg;
      owed.push_back(e);
    endfunction

    function automatic void check(logic [CoefBits-1:0] a, logic [CoefBits-1:0] b,
                                  logic [ConstBits-1:0] c, logic degen);
      bisector_t e;
      if (owed.size() == 0) begin
        $error("result arrived with nothing expected");
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (degen === 1'b1) degen_seen++;
      if (a !== e.a) begin
        $error("coef_a: expected %h, got %h", e.a, a);
        errors++;
      end
      if (b !== e.b) begin
        $error("coef_b: expected %h, got %h", e.b, b);
        errors++;
      end
      if (c !== e.c) begin
        $error("coef_c: expected %h, got %h", e.c, c);
        errors++;
      end
      if (degen !== e.degen) begin
        $error("degenerate: expected %b, got %b", e.degen, degen);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [15:0] vertex_x_i, vertex_y_i, first_x_i, first_y_i, second_x_i, second_y_i;
  logic done_o;
  logic [CoefBits-1:0] coef_a_o, coef_b_o;
  logic [ConstBits-1:0] coef_c_o;
  logic degenerate_o;

  bisector_board board;
  int unsigned idle_pct;
  int unsigned sent;
  int unsigned quiet_cycles;

  angle_bisector_line_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .vertex_x_i(vertex_x_i),
    .vertex_y_i(vertex_y_i),
    .first_x_i(first_x_i),
    .first_y_i(first_y_i),
    .second_x_i(second_x_i),
    .second_y_i(second_y_i),
    .done_o(done_o),
    .coef_a_o(coef_a_o),
    .coef_b_o(coef_b_o),
    .coef_c_o(coef_c_o),
    .degenerate_o(degenerate_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Results are sampled at the rising edge; the watchdog counts cycles in
  // which neither an input nor a result transfer takes place.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        board.check(coef_a_o, coef_b_o, coef_c_o, degenerate_o);
      end
      if (done_o === 1'b1 || (start && busy === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Called at a falling edge. The sender idles first as the current phase
  // asks, then holds start high until busy is low at a rising edge. It
  // returns on the next falling edge, so start is only ever assigned once
  // per time step.
  task automatic send_triple(logic [15:0] vx, logic [15:0] vy, logic [15:0] px,
                             logic [15:0] py, logic [15:0] qx, logic [15:0] qy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    vertex_x_i <= vx;
    vertex_y_i <= vy;
    first_x_i <= px;
    first_y_i <= py;
    second_x_i <= qx;
    second_y_i <= qy;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note(vx, vy, px, py, qx, qy);
    sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every owed line has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (board.owed.size() != 0) @(negedge clk_i);
  endtask

  // One random triple. Most are free points, some are small and close
  // together, and a share is built to hit the degenerate cases.
  task automatic random_triple();
    logic [15:0] v[6];
    int sel;
    int dx, dy, m, n, ox, oy;
    sel = $urandom_range(99);
    foreach (v[i]) v[i] = 16'($urandom);
    if (sel < 20) begin
      // Small neighborhood around a random vertex.
      ox = $signed(v[0]) / 2;
      oy = $signed(v[1]) / 2;
      v[0] = 16'(ox);
      v[1] = 16'(oy);
      v[2] = 16'(ox + $urandom_range(40) - 20);
      v[3] = 16'(oy + $urandom_range(40) - 20);
      v[4] = 16'(ox + $urandom_range(40) - 20);
      v[5] = 16'(oy + $urandom_range(40) - 20);
    end else if (sel < 28) begin
      // One arm point sits on the vertex.
      if ($urandom_range(1)) begin
        v[2] = v[0];
        v[3] = v[1];
      end else begin
        v[4] = v[0];
        v[5] = v[1];
      end
    end else if (sel < 40) begin
      // Collinear arms, pointing opposite ways or the same way.
      ox = $urandom_range(20000) - 10000;
      oy = $urandom_range(20000) - 10000;
      dx = $urandom_range(200) - 100;
      dy = $urandom_range(200) - 100;
      m = $urandom_range(50, 1);
      n = $urandom_range(50, 1);
      if ($urandom_range(3) == 0) n = -n;
      v[0] = 16'(ox);
      v[1] = 16'(oy);
      v[2] = 16'(ox + dx * m);
      v[3] = 16'(oy + dy * m);
      v[4] = 16'(ox - dx * n);
      v[5] = 16'(oy - dy * n);
    end
    send_triple(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic random_phase(int unsigned count, int unsigned pct);
    idle_pct = pct;
    repeat (count) random_triple();
  endtask

  initial begin
    board = new();
    idle_pct = 0;
    sent = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    vertex_x_i = '0;
    vertex_y_i = '0;
    first_x_i = '0;
    first_y_i = '0;
    second_x_i = '0;
    second_y_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: extreme coordinates, coincident points, collinear arms
    // on opposite and equal sides, a right angle and the widest spreads.
    send_triple(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_triple(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send_triple(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_triple(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_triple(16'h0005, 16'h0007, 16'h0005, 16'h0007, 16'h0100, 16'h0020);
    send_triple(16'h0005, 16'h0007, 16'h0100, 16'h0020, 16'h0005, 16'h0007);
    send_triple(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_triple(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_triple(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h8000, 16'h0000);
    send_triple(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h8001);
    send_triple(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'hffff, 16'hffff);
    send_triple(16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h7000, 16'h0000);
    send_triple(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_triple(16'h1234, 16'hedcb, 16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_triple(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_triple(16'h0000, 16'h0000, 16'h7fff, 16'h0001, 16'h8000, 16'h0000);
    send_triple(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h8000, 16'h0001);
    send_triple(16'h0010, 16'hfff0, 16'h0011, 16'hfff0, 16'h000f, 16'hfff0);

    // Random phases: back to back, a mostly idle sender, a lightly idle
    // sender, then back to back again. The sender waits for a full drain
    // between some of them.
    random_phase(500, 0);
    drain();
    random_phase(300, 88);
    random_phase(400, 20);
    drain();
    random_phase(400, 0);

    start <= 1'b0;
    @(negedge clk_i);
    while (board.owed.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d point triples, checked %0d bisector lines (%0d degenerate).",
             sent, board.checked, board.degen_seen);
    $display("Sender idle phases of 0, 88 and 20 percent, with two full drains.");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (board.owed.size() != 0) $error("%0d results never arrived", board.owed.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
